### rtl/pareto_front_ranker_top_macros.svh
// Assertion helpers for the Pareto front ranker
`ifndef PARETO_FRONT_RANKER_TOP_MACROS_SVH
`define PARETO_FRONT_RANKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define PFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/pfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;
    typedef logic [1:0] t_mode;

    localparam t_mode MODE_OBJ    = 2'd0;
    localparam t_mode MODE_VIOL   = 2'd1;
    localparam t_mode MODE_READ   = 2'd2;
    localparam t_mode MODE_UNUSED = 2'd3;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [1:0] CFG_NUM_OBJ = 2'd0;
    localparam logic [1:0] CFG_CONSTR  = 2'd1;

    localparam int unsigned NOBJ_W  = 4;
    localparam int unsigned RIDX_W  = 7;
    localparam int unsigned RANK_W  = 7;
    localparam int unsigned FRONT_W = 8;
endpackage
`default_nettype wire

### rtl/pareto_front_ranker_top.sv
// Pareto front ranker (fast non-dominated sort, minimisation).
// Input channel (i_valid/o_ready): load items in mode 0 (objective) or 1
// (violation) stream in at one per cycle when idle; end_of_individual closes
// an individual, end_of_population closes the population and starts the sort.
// Mode 2 reads the rank of one individual of the last sort; mode 3 is dropped.
// Output channel (o_valid/i_ready): one report item per sort, one reply item
// per read, held in an output register until taken.
// A read goes through the registered rank memory read and the ST_RD state.
// Sort steps, each bound by the single read port of its memory: a dominance
// build over the objective memory, then one pass over the dominance memory
// per front plus one final pass, then the report is posted.
// Load items that give no result are taken while a result waits; a read or
// an end-of-population item waits until the output register is free.
// Configuration (i_cfg_we) must be written only while idle; the block does not enforce it.
// Reset (synchronous, active low) empties the population, zeroes the front
// count and restores num_objectives to 2 and plain Pareto dominance.
`timescale 1ns / 1ps
`default_nettype none
`include "pareto_front_ranker_top_macros.svh"
module pareto_front_ranker_top
    import pfr_pkg::*;
#(
    parameter int MAX_POP     = 128,
    parameter int MAX_OBJ     = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [NOBJ_W-1:0]   i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_mode               i_mode,
    input  wire logic signed [31:0]  i_value,
    input  wire logic                i_end_of_individual,
    input  wire logic                i_end_of_population,
    input  wire logic [RIDX_W-1:0]   i_read_index,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_reply_kind,
    output logic [RANK_W-1:0]        o_rank,
    output logic [FRONT_W-1:0]       o_front_count,
    output logic [RIDX_W-1:0]        o_reply_index,
    output logic                     o_error
);
    localparam int VW   = VALUE_WIDTH;
    localparam int PW   = $clog2(MAX_POP);
    localparam int CW   = $clog2(MAX_POP + 1);
    localparam int OW   = (MAX_OBJ > 1) ? $clog2(MAX_OBJ) : 1;
    localparam int POSW = $clog2(MAX_OBJ + 1);
    localparam int MW   = $clog2(MAX_OBJ + 1);
    localparam int RW   = (MAX_OBJ + 1) * VW;
    localparam int XW   = (CW > RIDX_W) ? CW : RIDX_W;
    localparam int FW   = (CW > FRONT_W) ? CW : FRONT_W;
    localparam logic [VW-1:0] ZKEY = {1'b1, {(VW-1){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LDA  = 3'd2;
    localparam logic [2:0] ST_WA   = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_PASS = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // signed value to unsigned key with the same order
    function automatic logic [VW-1:0] f_key(input logic [31:0] v);
        logic [63:0] ext;
        ext = {{32{v[31]}}, v};
        return ext[VW-1:0] ^ ZKEY;
    endfunction

    logic [2:0]          r_state;
    logic [NOBJ_W-1:0]   r_nobj;
    logic                r_constr;
    logic                r_pop_open, n_pop_open;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [POSW-1:0]     r_pos, n_pos;
    logic                r_ovf, n_ovf;
    logic                r_ind_open, n_ind_open;
    logic [CW-1:0]       r_ranked, n_ranked;
    logic [VW-1:0]       r_buf [MAX_OBJ];
    logic [VW-1:0]       n_buf [MAX_OBJ];
    logic [VW-1:0]       r_vbuf, n_vbuf;

    logic [RW-1:0]       obj_mem [MAX_POP];
    logic [MAX_POP-1:0]  mat_mem [MAX_POP];
    logic [PW-1:0]       rank_mem [MAX_POP];
    logic [RW-1:0]       r_obj_q;
    logic [MAX_POP-1:0]  r_mat_q;
    logic [PW-1:0]       r_rank_q;

    logic                obj_we;
    logic [PW-1:0]       obj_waddr;
    logic [RW-1:0]       obj_wdata;

    logic [CW-1:0]       r_a, r_bi, r_j;
    logic [PW-1:0]       r_b1, r_j1;
    logic                r_v1, r_mv1;
    logic [RW-1:0]       r_rowa;
    logic [MAX_POP-1:0]  r_col, r_done, r_now;
    logic [CW-1:0]       r_front;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [RANK_W-1:0]   r_out_rank;
    logic [FRONT_W-1:0]  r_out_front;
    logic [RIDX_W-1:0]   r_out_index;
    logic                r_out_err;
    logic [RIDX_W-1:0]   r_ridx;
    logic                r_rd_ok;

    logic                produces, in_acc, load_acc, read_acc;
    logic [XW-1:0]       ridx_x;
    logic [PW-1:0]       ridx_addr;
    logic [VW-1:0]       key;
    logic [MW-1:0]       m_used;
    logic                lt_any, gt_any, dom;
    logic [VW-1:0]       va, vb;
    logic                fa, fb;
    logic [XW-1:0]       rank_x;
    logic [FW-1:0]       front_x;

    // handshake
    assign produces = (i_mode == MODE_READ) ||
                      ((i_mode != MODE_UNUSED) && i_end_of_population);
    assign o_ready  = (r_state == ST_IDLE) && (!r_out_valid || !produces);
    assign in_acc   = i_valid && o_ready;
    assign load_acc = in_acc && ((i_mode == MODE_OBJ) || (i_mode == MODE_VIOL));
    assign read_acc = in_acc && (i_mode == MODE_READ);
    assign key      = f_key(i_value);
    assign ridx_x   = XW'(i_read_index);
    assign ridx_addr = ridx_x[PW-1:0];

    // load bookkeeping and row assembly
    always_comb begin
        n_pop_open = r_pop_open;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_ovf      = r_ovf;
        n_ind_open = r_ind_open;
        n_ranked   = r_ranked;
        n_buf      = r_buf;
        n_vbuf     = r_vbuf;
        obj_we     = 1'b0;
        obj_waddr  = r_cnt[PW-1:0];
        if (load_acc) begin
            if (!r_pop_open) begin
                n_pop_open = 1'b1;
                n_cnt      = '0;
                n_pos      = '0;
                n_ovf      = 1'b0;
                n_ind_open = 1'b0;
                n_ranked   = '0;
            end
            if (n_cnt >= CW'(MAX_POP)) begin
                n_ovf = 1'b1;
            end else begin
                if (!n_ind_open) begin
                    for (int k = 0; k < MAX_OBJ; k++) n_buf[k] = ZKEY;
                    n_vbuf     = ZKEY;
                    n_pos      = '0;
                    n_ind_open = 1'b1;
                end
                if (i_mode == MODE_VIOL) begin
                    n_vbuf = key;
                end else if (n_pos < POSW'(MAX_OBJ)) begin
                    n_buf[n_pos[OW-1:0]] = key;
                    n_pos = n_pos + POSW'(1);
                end
            end
            if ((i_end_of_individual || i_end_of_population) && n_ind_open) begin
                obj_we     = 1'b1;
                obj_waddr  = n_cnt[PW-1:0];
                n_cnt      = n_cnt + CW'(1);
                n_ind_open = 1'b0;
                n_pos      = '0;
            end
            if (i_end_of_population) begin
                n_pop_open = 1'b0;
                n_ranked   = n_cnt;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_OBJ; k++) obj_wdata[k*VW +: VW] = n_buf[k];
        obj_wdata[MAX_OBJ*VW +: VW] = n_vbuf;
    end

    // objectives in use
    always_comb begin
        if (r_nobj == '0) begin
            m_used = MW'(1);
        end else if (MW'(r_nobj) > MW'(MAX_OBJ)) begin
            m_used = MW'(MAX_OBJ);
        end else begin
            m_used = MW'(r_nobj);
        end
    end

    // does row b (just read) dominate row a
    always_comb begin
        lt_any = 1'b0;
        gt_any = 1'b0;
        for (int k = 0; k < MAX_OBJ; k++) begin
            if (MW'(k) < m_used) begin
                if (r_obj_q[k*VW +: VW] < r_rowa[k*VW +: VW]) lt_any = 1'b1;
                if (r_obj_q[k*VW +: VW] > r_rowa[k*VW +: VW]) gt_any = 1'b1;
            end
        end
        vb  = r_obj_q[MAX_OBJ*VW +: VW];
        va  = r_rowa[MAX_OBJ*VW +: VW];
        fb  = (vb <= ZKEY);
        fa  = (va <= ZKEY);
        dom = lt_any && !gt_any;
        if (r_constr) begin
            if (fb && !fa) begin
                dom = 1'b1;
            end else if (!fb && fa) begin
                dom = 1'b0;
            end else if (!fb && !fa) begin
                dom = (vb < va);
            end
        end
    end

    // widen results for the saturating compare
    assign rank_x  = XW'(r_rank_q);
    assign front_x = FW'(r_front);

    // objective memory
    always_ff @(posedge i_clk) begin
        if (obj_we) obj_mem[obj_waddr] <= obj_wdata;
        if (r_state == ST_LDA) begin
            r_obj_q <= obj_mem[r_a[PW-1:0]];
        end else if (r_state == ST_SCAN && r_bi < r_cnt) begin
            r_obj_q <= obj_mem[r_bi[PW-1:0]];
        end
    end

    // dominance memory: row j holds the dominators of j
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_bi == r_cnt && !r_v1) mat_mem[r_a[PW-1:0]] <= r_col;
        if (r_state == ST_PASS && r_j < r_cnt) r_mat_q <= mat_mem[r_j[PW-1:0]];
    end

    // rank memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PASS && r_mv1 && !r_done[r_j1] && ((r_mat_q & ~r_done) == '0)) begin
            rank_mem[r_j1] <= r_front[PW-1:0];
        end
        if (read_acc) r_rank_q <= rank_mem[ridx_addr];
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nobj      <= NOBJ_W'(2);
            r_constr    <= 1'b0;
            r_pop_open  <= 1'b0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_ind_open  <= 1'b0;
            r_ranked    <= '0;
            r_front     <= '0;
            r_done      <= '0;
            r_now       <= '0;
            r_v1        <= 1'b0;
            r_mv1       <= 1'b0;
            r_a         <= '0;
            r_bi        <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_OBJ) r_nobj <= i_cfg_data;
                if (i_cfg_index == CFG_CONSTR) r_constr <= i_cfg_data[0];
            end
            r_pop_open <= n_pop_open;
            r_cnt      <= n_cnt;
            r_pos      <= n_pos;
            r_ovf      <= n_ovf;
            r_ind_open <= n_ind_open;
            r_ranked   <= n_ranked;
            r_buf      <= n_buf;
            r_vbuf     <= n_vbuf;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (read_acc) begin
                        r_ridx  <= i_read_index;
                        r_rd_ok <= (ridx_x < XW'(r_ranked)) && r_done[ridx_addr];
                        r_out_err <= !(ridx_x < XW'(r_ranked));
                        r_state <= ST_RD;
                    end else if (load_acc && i_end_of_population) begin
                        r_a     <= '0;
                        r_done  <= '0;
                        r_state <= ST_LDA;
                    end
                end
                ST_RD: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= KIND_READ;
                    r_out_index <= r_ridx;
                    r_out_front <= (front_x > FW'(255)) ? 8'd255 : front_x[FRONT_W-1:0];
                    if (!r_rd_ok) begin
                        r_out_rank <= '0;
                    end else if (rank_x > XW'(127)) begin
                        r_out_rank <= 7'd127;
                    end else begin
                        r_out_rank <= rank_x[RANK_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
                ST_LDA: begin
                    if (r_a == r_cnt) begin
                        r_j     <= '0;
                        r_mv1   <= 1'b0;
                        r_now   <= '0;
                        r_front <= '0;
                        r_state <= ST_PASS;
                    end else begin
                        r_state <= ST_WA;
                    end
                end
                ST_WA: begin
                    r_rowa  <= r_obj_q;
                    r_col   <= '0;
                    r_bi    <= '0;
                    r_v1    <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_bi < r_cnt) begin
                        r_bi <= r_bi + CW'(1);
                        r_b1 <= r_bi[PW-1:0];
                        r_v1 <= 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    if (r_v1) r_col[r_b1] <= dom;
                    if (r_bi == r_cnt && !r_v1) begin
                        r_a     <= r_a + CW'(1);
                        r_state <= ST_LDA;
                    end
                end
                ST_PASS: begin
                    if (r_j < r_cnt) begin
                        r_j   <= r_j + CW'(1);
                        r_j1  <= r_j[PW-1:0];
                        r_mv1 <= 1'b1;
                    end else begin
                        r_mv1 <= 1'b0;
                    end
                    if (r_mv1 && !r_done[r_j1] && ((r_mat_q & ~r_done) == '0)) begin
                        r_now[r_j1] <= 1'b1;
                    end
                    if (r_j == r_cnt && !r_mv1) begin
                        if (r_now == '0) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_done  <= r_done | r_now;
                            r_now   <= '0;
                            r_front <= r_front + CW'(1);
                            r_j     <= '0;
                        end
                    end
                end
                ST_FIN: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= KIND_REPORT;
                    r_out_rank  <= '0;
                    r_out_index <= '0;
                    r_out_err   <= r_ovf;
                    r_out_front <= (front_x > FW'(255)) ? 8'd255 : front_x[FRONT_W-1:0];
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_reply_kind  = r_out_kind;
    assign o_rank        = r_out_rank;
    assign o_front_count = r_out_front;
    assign o_reply_index = r_out_index;
    assign o_error       = r_out_err;

    // population never exceeds the memory
    `PFR_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_POP))
    // an item with a result only enters when the output register is free
    `PFR_ASSERT_IMP(a_slot_free, i_clk, i_rst_n, in_acc && produces, !r_out_valid)
    // a finished sort always posts its report
    `PFR_ASSERT_NEXT(a_report, i_clk, i_rst_n, r_state == ST_FIN, r_out_valid)
endmodule
`default_nettype wire

### tb/sv/pareto_front_ranker_top_tb.sv
`timescale 1ns / 1ps
module pareto_front_ranker_top_tb;
    import pfr_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [RANK_W-1:0] rank;
        logic [FRONT_W-1:0] fronts;
        logic [RIDX_W-1:0] index;
        logic              err;
    } reply_t;

    // Sort predictor and store of expected replies
    class rank_scoreboard;
        logic signed [31:0] objv [128][8];
        logic signed [31:0] viol [128];
        bit                 dom [128][128];
        int unsigned        rank_of [128];
        int unsigned        n_ind, obj_pos, fronts, n_ranked, n_obj_cfg;
        bit                 constr_cfg, ovf, ind_open, pop_open;
        reply_t             expected_q [$];
        int                 errors;

        function new();
            n_obj_cfg  = 2;
            constr_cfg = 0;
            n_ind = 0; obj_pos = 0; fronts = 0; n_ranked = 0;
            ovf = 0; ind_open = 0; pop_open = 0; errors = 0;
        endfunction

        function void write_cfg(logic [1:0] idx, logic [NOBJ_W-1:0] data);
            if (idx == CFG_NUM_OBJ) n_obj_cfg = data;
            else if (idx == CFG_CONSTR) constr_cfg = data[0];
        endfunction

        function bit dominates(int a, int b, int m);
            bit fa, fb, better;
            if (constr_cfg) begin
                fa = viol[a] <= 0;
                fb = viol[b] <= 0;
                if (fa && !fb) return 1;
                if (!fa && fb) return 0;
                if (!fa && !fb) return viol[a] < viol[b];
            end
            better = 0;
            for (int k = 0; k < m; k++) begin
                if (objv[a][k] > objv[b][k]) return 0;
                if (objv[a][k] < objv[b][k]) better = 1;
            end
            return better;
        endfunction

        // Build dominance, count dominators, then peel fronts
        function void sort_population();
            int unsigned m, left, got;
            int unsigned cnt [128];
            bit          done [128];
            bit          peeled [128];
            m = (n_obj_cfg == 0) ? 1 : (n_obj_cfg > 8 ? 8 : n_obj_cfg);
            left = n_ind;
            fronts = 0;
            for (int i = 0; i < n_ind; i++) begin
                cnt[i] = 0; rank_of[i] = 0; done[i] = 0;
            end
            for (int i = 0; i < n_ind; i++)
                for (int j = 0; j < n_ind; j++)
                    dom[i][j] = (i != j) && dominates(i, j, m);
            for (int i = 0; i < n_ind; i++)
                for (int j = 0; j < n_ind; j++)
                    if (dom[j][i]) cnt[i]++;
            while (left > 0 && fronts < n_ind) begin
                got = 0;
                for (int i = 0; i < n_ind; i++) begin
                    peeled[i] = !done[i] && cnt[i] == 0;
                    if (peeled[i]) begin
                        rank_of[i] = fronts; done[i] = 1; got++;
                    end
                end
                if (got == 0) break;
                left -= got;
                fronts++;
                for (int i = 0; i < n_ind; i++)
                    if (peeled[i])
                        for (int j = 0; j < n_ind; j++)
                            if (dom[i][j] && cnt[j] > 0) cnt[j]--;
            end
            n_ranked = n_ind;
        endfunction

        function void note_item(t_mode mode, logic signed [31:0] v, bit eoi, bit eop,
                                logic [RIDX_W-1:0] ridx);
            reply_t r;
            if (mode == MODE_READ) begin
                r.kind   = KIND_READ;
                r.err    = !(ridx < n_ranked);
                r.rank   = RANK_W'(r.err ? 0 : (rank_of[ridx] > 127 ? 127 : rank_of[ridx]));
                r.fronts = FRONT_W'(fronts > 255 ? 255 : fronts);
                r.index  = ridx;
                expected_q.push_back(r);
                return;
            end
            if (mode == MODE_UNUSED) return;
            if (!pop_open) begin
                pop_open = 1; n_ind = 0; obj_pos = 0; ovf = 0; ind_open = 0; n_ranked = 0;
            end
            if (n_ind >= 128) begin
                ovf = 1;
            end else begin
                if (!ind_open) begin
                    for (int k = 0; k < 8; k++) objv[n_ind][k] = 0;
                    viol[n_ind] = 0;
                    obj_pos = 0;
                    ind_open = 1;
                end
                if (mode == MODE_VIOL) begin
                    viol[n_ind] = v;
                end else if (obj_pos < 8) begin
                    objv[n_ind][obj_pos] = v;
                    obj_pos++;
                end
            end
            if ((eoi || eop) && ind_open) begin
                n_ind++; ind_open = 0; obj_pos = 0;
            end
            if (!eop) return;
            sort_population();
            pop_open = 0;
            r.kind   = KIND_REPORT;
            r.rank   = '0;
            r.fronts = FRONT_W'(fronts > 255 ? 255 : fronts);
            r.index  = '0;
            r.err    = ovf;
            expected_q.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected reply kind %0d rank %0d fronts %0d index %0d err %0d",
                         $time, got.kind, got.rank, got.fronts, got.index, got.err);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected kind %0d rank %0d fronts %0d index %0d err %0d",
                         $time, exp_r.kind, exp_r.rank, exp_r.fronts, exp_r.index, exp_r.err);
                $display("%0t:          actual   kind %0d rank %0d fronts %0d index %0d err %0d",
                         $time, got.kind, got.rank, got.fronts, got.index, got.err);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_NUM_OBJ;
    logic [NOBJ_W-1:0]  i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_mode              i_mode = MODE_OBJ;
    logic signed [31:0] i_value = '0;
    logic               i_end_of_individual = 1'b0;
    logic               i_end_of_population = 1'b0;
    logic [RIDX_W-1:0]  i_read_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_reply_kind;
    logic [RANK_W-1:0]  o_rank;
    logic [FRONT_W-1:0] o_front_count;
    logic [RIDX_W-1:0]  o_reply_index;
    logic               o_error;

    rank_scoreboard sb = new();
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_left = 0;
    bit          hold_req = 0;
    int          sent = 0;

    pareto_front_ranker_top uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("** pareto_front_ranker_top: FAILED **");
        $finish;
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) hold_left = 400;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Note accepted items and check replies
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_item(i_mode, i_value, i_end_of_individual, i_end_of_population,
                         i_read_index);
        if (i_rst_n && o_valid && i_ready)
            sb.check_reply({o_reply_kind, o_rank, o_front_count, o_reply_index, o_error});
    end

    task automatic send(t_mode mode, logic signed [31:0] v, bit eoi, bit eop,
                        logic [RIDX_W-1:0] ridx);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_mode              <= mode;
        i_value             <= v;
        i_end_of_individual <= eoi;
        i_end_of_population <= eop;
        i_read_index        <= ridx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic read_rank(logic [RIDX_W-1:0] ridx);
        send(MODE_READ, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), ridx);
    endtask

    // Hold the sender until every reply is in, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [NOBJ_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_cfg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(6)) - 3;
        endcase
    endfunction

    // One well-formed population with random content, then a few reads
    task automatic random_population();
        int n, k;
        bit last;
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            k = ($urandom_range(4) == 0) ? $urandom_range(1, 10) : sb.n_obj_cfg;
            if (k == 0) k = 1;
            if ($urandom_range(2) == 0) send(MODE_VIOL, rand_value(), 0, 0, RIDX_W'($urandom));
            for (int j = 0; j < k; j++) begin
                last = (j == k - 1);
                send(MODE_OBJ, rand_value(), last, last && i == n - 1, RIDX_W'($urandom));
            end
            if ($urandom_range(9) == 0) send(MODE_UNUSED, $urandom, 1, 1, RIDX_W'($urandom));
        end
        repeat ($urandom_range(1, 4))
            read_rank(RIDX_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(n)));
    endtask

    task automatic random_phase(int upto);
        while (sent < upto) begin
            if ($urandom_range(3) == 0) begin
                drain();
                write_cfg(CFG_NUM_OBJ, NOBJ_W'($urandom));
                write_cfg(CFG_CONSTR, NOBJ_W'($urandom));
            end
            if ($urandom_range(7) == 0) begin
                // broken sequence: violation-only close, read mid-load
                send(MODE_VIOL, rand_value(), 0, 0, 0);
                read_rank(RIDX_W'($urandom));
                send(MODE_VIOL, rand_value(), 0, 1, 0);
            end else begin
                random_population();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: read before any sort, unused mode, extremes and ties
        read_rank(0);
        send(MODE_UNUSED, 0, 0, 1, 0);
        send(MODE_OBJ, 32'sh80000000, 0, 0, 0);
        send(MODE_OBJ, 32'sh7fffffff, 1, 0, 0);
        send(MODE_OBJ, 32'sh7fffffff, 0, 0, 0);
        send(MODE_OBJ, 32'sh80000000, 1, 0, 0);
        send(MODE_OBJ, 32'sh80000000, 0, 0, 0);
        send(MODE_OBJ, 32'sh7fffffff, 1, 0, 0);
        send(MODE_OBJ, 0, 0, 1, 0);
        read_rank(0);
        read_rank(3);
        read_rank(4);
        read_rank(127);
        drain();

        // Constrained dominance, objective count of one, too many values
        write_cfg(CFG_CONSTR, 1);
        write_cfg(CFG_NUM_OBJ, 1);
        send(MODE_VIOL, 5, 0, 0, 0);
        send(MODE_OBJ, 0, 1, 0, 0);
        send(MODE_VIOL, -1, 0, 0, 0);
        send(MODE_OBJ, 7, 1, 0, 0);
        send(MODE_VIOL, 5, 0, 0, 0);
        send(MODE_OBJ, -3, 1, 0, 0);
        for (int j = 0; j < 9; j++) send(MODE_OBJ, j - 4, 0, j == 8, 0);
        read_rank(1);
        read_rank(2);
        drain();

        // Full population plus overflow, one front per individual
        write_cfg(CFG_CONSTR, 0);
        write_cfg(CFG_NUM_OBJ, 0);
        for (int i = 0; i < 130; i++) send(MODE_OBJ, 1000 - i, 1, i == 129, 0);
        read_rank(0);
        read_rank(127);
        drain();
        write_cfg(CFG_NUM_OBJ, 15);
        write_cfg(CFG_CONSTR, 1);

        snd_idle = 13; rcv_idle = 45;
        random_phase(250);
        drain();
        write_cfg(CFG_NUM_OBJ, 8);
        snd_idle = 45; rcv_idle = 13;
        random_phase(340);
        drain();
        write_cfg(CFG_NUM_OBJ, 2);
        write_cfg(CFG_CONSTR, 0);
        snd_idle = 0; rcv_idle = 0;

        // Long receiver hold-off while reads keep coming
        hold_req = 1;
        wait (hold_left > 0);
        hold_req = 0;
        repeat (12) read_rank(RIDX_W'($urandom));
        random_phase(450);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** pareto_front_ranker_top: PASSED **");
        else
            $display("** pareto_front_ranker_top: FAILED **");
        $finish;
    end
endmodule

### pareto_front_ranker_top.f
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pareto_front_ranker_top.sv
tb/sv/pareto_front_ranker_top_tb.sv
